// ----- rtl/cdeq_pkg.sv -----
// shared types, constants and helper functions for the circular deque
`timescale 1ns / 1ps

package cdeq_pkg;

    // queue geometry
    localparam int DEPTH      = 16;
    localparam int DATA_WIDTH = 32;
    localparam int PTR_W      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int FILL_W     = $clog2(DEPTH + 1);

    // request and result field widths
    localparam int OP_W    = 3;
    localparam int VALUE_W = 32;
    localparam int POS_W   = 6;
    localparam int DOUT_W  = 32;
    localparam int COUNT_W = 7;
    localparam int STAT_W  = 2;

    // packed bus layout, lowest field first, padded to bytes
    localparam int OP_LSB     = 0;
    localparam int VALUE_LSB  = OP_LSB + OP_W;
    localparam int POS_LSB    = VALUE_LSB + VALUE_W;
    localparam int S_FIELDS_W = POS_LSB + POS_W;
    localparam int S_TDATA_W  = ((S_FIELDS_W + 7) / 8) * 8;
    localparam int M_FIELDS_W = DOUT_W + COUNT_W;
    localparam int M_TDATA_W  = ((M_FIELDS_W + 7) / 8) * 8;

    // width for the front offset sum before wrap
    localparam int SUM_W = ((PTR_W > POS_W) ? PTR_W : POS_W) + 1;
    // width for position against fill compare
    localparam int CMP_W = (FILL_W > POS_W) ? FILL_W : POS_W;

    // operation codes
    typedef enum logic [OP_W-1:0] {
        OP_PUSH_BACK  = 3'd0,
        OP_PUSH_FRONT = 3'd1,
        OP_POP_BACK   = 3'd2,
        OP_POP_FRONT  = 3'd3,
        OP_CLEAR      = 3'd4,
        OP_GET        = 3'd5,
        OP_DUMP       = 3'd6,
        OP_SIZE       = 3'd7
    } op_t;

    // result status codes
    typedef enum logic [STAT_W-1:0] {
        STAT_OK    = 2'd0,
        STAT_FULL  = 2'd1,
        STAT_EMPTY = 2'd2,
        STAT_RANGE = 2'd3
    } status_t;

    // one result
    typedef struct packed {
        logic [DOUT_W-1:0]  data;
        logic [COUNT_W-1:0] count;
        status_t            status;
        logic               last;
    } res_t;

    // result handed from the sequencer to the output queue
    typedef struct packed {
        logic valid;
        res_t res;
    } res_push_t;

    // output queue state seen by the sequencer
    typedef struct packed {
        logic [1:0] level;
        logic       pop;
    } oq_stat_t;

    // store access
    typedef struct packed {
        logic                  we;
        logic [PTR_W-1:0]      waddr;
        logic [DATA_WIDTH-1:0] wdata;
        logic                  re;
        logic [PTR_W-1:0]      raddr;
    } mem_req_t;

    // sign-extend the request value then keep the stored width
    function automatic logic [DATA_WIDTH-1:0] to_store(input logic [VALUE_W-1:0] v);
        logic signed [63:0] ext;
        ext = 64'(signed'(v));
        return ext[DATA_WIDTH-1:0];
    endfunction

    // sign-extend a stored element to the result data field
    function automatic logic [DOUT_W-1:0] to_out(input logic [DATA_WIDTH-1:0] d);
        logic signed [63:0] ext;
        ext = 64'(signed'(d));
        return ext[DOUT_W-1:0];
    endfunction

    // circular pointer step forward
    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    // circular pointer step back
    function automatic logic [PTR_W-1:0] ptr_dec(input logic [PTR_W-1:0] p);
        return (p == '0) ? PTR_W'(DEPTH - 1) : p - PTR_W'(1);
    endfunction

endpackage

// ----- rtl/cdeq_store.sv -----
// element store: one write port, one read port with registered data
`timescale 1ns / 1ps

module cdeq_store (
    input  logic                           aclk,
    input  cdeq_pkg::mem_req_t             req,
    output logic [cdeq_pkg::DATA_WIDTH-1:0] rdata
);
    import cdeq_pkg::*;

    logic [DATA_WIDTH-1:0] mem [DEPTH];
    logic [DATA_WIDTH-1:0] rdata_reg;

    // write port
    always_ff @(posedge aclk) begin
        if (req.we) begin
            mem[req.waddr] <= req.wdata;
        end
    end

    // read port, data registered on a read enable
    always_ff @(posedge aclk) begin
        if (req.re) begin
            rdata_reg <= mem[req.raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/cdeq_ctrl.sv -----
// request sequencer: pointers, fill count, store accesses and dump walk
`timescale 1ns / 1ps

module cdeq_ctrl (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [cdeq_pkg::S_TDATA_W-1:0]  s_tdata,
    input  cdeq_pkg::oq_stat_t              oq_stat,
    output cdeq_pkg::res_push_t             res_push,
    output cdeq_pkg::mem_req_t              mem_req,
    input  logic [cdeq_pkg::DATA_WIDTH-1:0] rdata
);
    import cdeq_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_DUMP = 2'b10
    } state_t;

    state_t             state_reg, state_next;
    logic [PTR_W-1:0]   head_reg, head_next;
    logic [PTR_W-1:0]   tail_reg, tail_next;
    logic [FILL_W-1:0]  fill_reg, fill_next;
    logic [PTR_W-1:0]   walk_reg, walk_next;
    logic [FILL_W-1:0]  left_reg, left_next;
    logic               rd_pend_reg, rd_pend_next;
    logic               rd_last_reg, rd_last_next;

    op_t                op;
    logic [VALUE_W-1:0] value;
    logic [POS_W-1:0]   position;
    logic               accept;
    logic               full;
    logic               empty;
    logic               in_range;
    logic [SUM_W-1:0]   sum;
    logic [PTR_W-1:0]   get_addr;
    logic               room;
    logic               imm_valid;
    status_t            imm_status;

    // request fields
    assign op       = op_t'(s_tdata[OP_LSB +: OP_W]);
    assign value    = s_tdata[VALUE_LSB +: VALUE_W];
    assign position = s_tdata[POS_LSB +: POS_W];

    assign full  = (fill_reg == FILL_W'(DEPTH));
    assign empty = (fill_reg == '0);

    // one request at a time, and only with a free output slot
    assign s_tready = (state_reg == S_IDLE) && !rd_pend_reg && (oq_stat.level < 2'd2);
    assign accept   = s_tvalid && s_tready;

    // front offset to store address, wraps at most once
    assign in_range = CMP_W'(position) < CMP_W'(fill_reg);
    assign sum      = SUM_W'(head_reg) + SUM_W'(position);
    assign get_addr = (sum >= SUM_W'(DEPTH)) ? PTR_W'(sum - SUM_W'(DEPTH)) : PTR_W'(sum);

    // a dump read may issue if its data will find a free slot next cycle
    assign room = (3'(oq_stat.level) + 3'(rd_pend_reg)) < (3'd2 + 3'(oq_stat.pop));

    // next state and store access
    always_comb begin
        state_next   = state_reg;
        head_next    = head_reg;
        tail_next    = tail_reg;
        fill_next    = fill_reg;
        walk_next    = walk_reg;
        left_next    = left_reg;
        rd_pend_next = 1'b0;
        rd_last_next = rd_last_reg;
        imm_valid    = 1'b0;
        imm_status   = STAT_OK;
        mem_req      = '0;
        mem_req.wdata = to_store(value);

        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    imm_valid = 1'b1;
                    unique case (op)
                        OP_PUSH_BACK: begin
                            if (full) begin
                                imm_status = STAT_FULL;
                            end else begin
                                mem_req.we    = 1'b1;
                                mem_req.waddr = tail_reg;
                                tail_next     = ptr_inc(tail_reg);
                                fill_next     = fill_reg + FILL_W'(1);
                            end
                        end
                        OP_PUSH_FRONT: begin
                            if (full) begin
                                imm_status = STAT_FULL;
                            end else begin
                                mem_req.we    = 1'b1;
                                mem_req.waddr = ptr_dec(head_reg);
                                head_next     = ptr_dec(head_reg);
                                fill_next     = fill_reg + FILL_W'(1);
                            end
                        end
                        OP_POP_BACK: begin
                            if (empty) begin
                                imm_status = STAT_EMPTY;
                            end else begin
                                tail_next = ptr_dec(tail_reg);
                                fill_next = fill_reg - FILL_W'(1);
                            end
                        end
                        OP_POP_FRONT: begin
                            if (empty) begin
                                imm_status = STAT_EMPTY;
                            end else begin
                                head_next = ptr_inc(head_reg);
                                fill_next = fill_reg - FILL_W'(1);
                            end
                        end
                        OP_CLEAR: begin
                            head_next = '0;
                            tail_next = '0;
                            fill_next = '0;
                        end
                        OP_GET: begin
                            if (!in_range) begin
                                imm_status = STAT_RANGE;
                            end else begin
                                imm_valid     = 1'b0;
                                mem_req.re    = 1'b1;
                                mem_req.raddr = get_addr;
                                rd_pend_next  = 1'b1;
                                rd_last_next  = 1'b1;
                            end
                        end
                        OP_DUMP: begin
                            if (empty) begin
                                imm_status = STAT_EMPTY;
                            end else begin
                                imm_valid  = 1'b0;
                                walk_next  = head_reg;
                                left_next  = fill_reg;
                                state_next = S_DUMP;
                            end
                        end
                        OP_SIZE: begin
                            imm_status = STAT_OK;
                        end
                        default: begin
                            imm_status = STAT_OK;
                        end
                    endcase
                end
            end
            S_DUMP: begin
                // one element read per cycle while the output keeps up
                if (room) begin
                    mem_req.re    = 1'b1;
                    mem_req.raddr = walk_reg;
                    walk_next     = ptr_inc(walk_reg);
                    left_next     = left_reg - FILL_W'(1);
                    rd_pend_next  = 1'b1;
                    rd_last_next  = (left_reg == FILL_W'(1));
                    if (left_reg == FILL_W'(1)) begin
                        state_next = S_IDLE;
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // result: read data when it lands, otherwise the immediate answer
    always_comb begin
        res_push = '0;
        if (rd_pend_reg) begin
            res_push.valid      = 1'b1;
            res_push.res.data   = to_out(rdata);
            res_push.res.count  = COUNT_W'(fill_reg);
            res_push.res.status = STAT_OK;
            res_push.res.last   = rd_last_reg;
        end else if (imm_valid) begin
            res_push.valid      = 1'b1;
            res_push.res.data   = '0;
            res_push.res.count  = COUNT_W'(fill_next);
            res_push.res.status = imm_status;
            res_push.res.last   = 1'b1;
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            head_reg    <= '0;
            tail_reg    <= '0;
            fill_reg    <= '0;
            left_reg    <= '0;
            rd_pend_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            head_reg    <= head_next;
            tail_reg    <= tail_next;
            fill_reg    <= fill_next;
            left_reg    <= left_next;
            rd_pend_reg <= rd_pend_next;
        end
    end

    // walk pointer and last flag
    always_ff @(posedge aclk) begin
        walk_reg    <= walk_next;
        rd_last_reg <= rd_last_next;
    end

endmodule

// ----- rtl/circular_double_ended_queue.sv -----
// top level of the circular deque: sequencer, store and two-entry output queue
`timescale 1ns / 1ps

// channel | dir | tdata (low bit up)                        | tuser  | tlast
// s_      | in  | op[2:0] value[34:3] position[40:35], pad    | -      | -
// m_      | out | data[31:0] count[38:32], pad               | status | last
//
// push, pop, clear, size and an out-of-range get are answered directly, with no store read.
// an in-range get does one store read, and its result carries the registered read data.
// a dump reads one stored element per cycle through the single store read port while the output keeps up.
// a two-entry output queue lets the next request in while a result waits.
// reset is taken on the clock edge and clears pointers and fill count; store contents are kept as they are.
module circular_double_ended_queue (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [cdeq_pkg::S_TDATA_W-1:0] s_tdata,  // op, value, position
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [cdeq_pkg::M_TDATA_W-1:0] m_tdata,  // data, count
    output logic [cdeq_pkg::STAT_W-1:0]    m_tuser,  // status
    output logic                           m_tlast
);
    import cdeq_pkg::*;

    res_push_t             res_push;
    oq_stat_t              oq_stat;
    mem_req_t              mem_req;
    logic [DATA_WIDTH-1:0] rdata;

    res_t                  oq_mem [2];
    logic                  wr_ptr_reg;
    logic                  rd_ptr_reg;
    logic [1:0]            level_reg;
    logic                  pop;
    res_t                  head_res;

    cdeq_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .oq_stat  (oq_stat),
        .res_push (res_push),
        .mem_req  (mem_req),
        .rdata    (rdata)
    );

    cdeq_store u_store (
        .aclk  (aclk),
        .req   (mem_req),
        .rdata (rdata)
    );

    // output queue status
    assign pop           = m_tvalid && m_tready;
    assign oq_stat.level = level_reg;
    assign oq_stat.pop   = pop;

    // output queue payload
    always_ff @(posedge aclk) begin
        if (res_push.valid) begin
            oq_mem[wr_ptr_reg] <= res_push.res;
        end
    end

    // output queue pointers and level
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            level_reg  <= '0;
        end else begin
            if (res_push.valid) begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            level_reg <= level_reg + 2'(res_push.valid) - 2'(pop);
        end
    end

    // result channel
    assign head_res = oq_mem[rd_ptr_reg];
    assign m_tvalid = (level_reg != '0);
    assign m_tdata  = M_TDATA_W'({head_res.count, head_res.data});
    assign m_tuser  = head_res.status;
    assign m_tlast  = head_res.last;

endmodule
